/* rtl/core/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define CHECK_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also runs during reset
`define CHECK_CLK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/core/oils_pkg.sv */
`timescale 1ns / 1ps

package oils_pkg;

   // command carried with each input transfer
   typedef enum logic [1:0] {
      CMD_INS_HEAD = 2'd0,
      CMD_INS_TAIL = 2'd1,
      CMD_REM_VAL  = 2'd2,
      CMD_REM_HEAD = 2'd3
   } cmd_type;

   // result status
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // per-transfer strobes broadcast to every cell, already qualified
   typedef struct packed {
      logic ins_head;
      logic ins_tail;
      logic rem_head;
      logic rem_val;
   } cell_ctrl_type;

   localparam int VALUE_W = 32;
   localparam int COUNT_OUT_W = 5;

endpackage

/* rtl/core/ordered_int_list_store.sv */
`timescale 1ns / 1ps

// Bounded ordered list of signed 32-bit values held in a row of CAPACITY
// cells, cell 0 being the head. Each input transfer carries a command in
// req_tuser (insert at head, insert at tail, remove first equal value,
// remove head) and a value in req_tdata, and yields exactly one result
// transfer with the head value after the command (0 when empty), the entry
// count and a status (ok, not found or empty, full). One command is taken
// every clock cycle; the cycle is set by the per-cell 32-bit compare and
// the first-match chain that runs across all cells, so its depth grows
// with CAPACITY. A result is registered and the next command is taken while
// it waits, as long as the result register is empty or being drained.
// Entry contents are not cleared by reset; only the count and the result valid flag are.

`include "assert_macros.svh"

module ordered_int_list_store
   import oils_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] value
   input  logic [1:0]  req_tuser,  // [1:0] cmd
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // [31:0] head_value, [36:32] entry_count,
                                   // [38:37] status, [39] zero
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic                  acc;
   cmd_type               cmd;
   logic [VALUE_W-1:0]    value;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  full;
   logic                  empty;
   logic                  found;
   cell_ctrl_type         ctrl;
   status_type            status_in;
   logic [VALUE_W-1:0]    head_in;
   logic                  rsp_valid_ff;
   logic [39:0]           rsp_data_ff;
   logic [CNT_W+COUNT_OUT_W-1:0] cnt_wide;

   logic [VALUE_W-1:0]    cell_data [CAPACITY];
   logic [CAPACITY:0]     hit;

   // handshake
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign acc        = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign value      = req_tdata;

   assign full  = (count_ff == CAP_CNT);
   assign empty = (count_ff == '0);
   assign found = hit[CAPACITY];

   // command strobes for the cells
   always_comb begin
      ctrl.ins_head = acc && (cmd == CMD_INS_HEAD) && !full;
      ctrl.ins_tail = acc && (cmd == CMD_INS_TAIL) && !full;
      ctrl.rem_head = acc && (cmd == CMD_REM_HEAD) && !empty;
      ctrl.rem_val  = acc && (cmd == CMD_REM_VAL);
   end

   // cell row
   assign hit[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] left_d;
      logic [VALUE_W-1:0] right_d;

      if (i == 0) begin : g_first
         assign left_d = value;
      end else begin : g_mid_l
         assign left_d = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_mid_r
         assign right_d = cell_data[i+1];
      end

      oils_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .value      (value),
         .left_data  (left_d),
         .right_data (right_d),
         .hit_in     (hit[i]),
         .hit_out    (hit[i+1]),
         .data_out   (cell_data[i])
      );
   end

   // status and next count
   always_comb begin
      status_in = ST_OK;
      count_in  = count_ff;
      unique case (cmd)
         CMD_INS_HEAD, CMD_INS_TAIL: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         CMD_REM_VAL: begin
            if (found) begin
               count_in = count_ff - 1'b1;
            end else begin
               status_in = ST_MISS;
            end
         end
         CMD_REM_HEAD: begin
            if (empty) begin
               status_in = ST_MISS;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // head value after the command
   always_comb begin
      head_in = cell_data[0];
      if (count_in == '0) begin
         head_in = '0;
      end else if (ctrl.ins_head) begin
         head_in = value;
      end else if (ctrl.ins_tail && empty) begin
         head_in = value;
      end else if (ctrl.rem_head || (ctrl.rem_val && hit[1])) begin
         head_in = cell_data[1];
      end
   end

   // count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (acc) begin
         count_ff <= count_in;
      end
   end

   assign cnt_wide = {{COUNT_OUT_W{1'b0}}, count_in};

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (acc) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         rsp_data_ff <= {1'b0, status_in, cnt_wide[COUNT_OUT_W-1:0], head_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `CHECK_CLK(a_count_bound, count_ff <= CAP_CNT, "count above capacity")
   `CHECK_CLK(a_full_only_at_cap, acc && (status_in == ST_FULL) |-> full,
              "full status below capacity")
   `CHECK_CLK(a_ins_grows, ctrl.ins_head || ctrl.ins_tail |=> count_ff == $past(count_ff) + 1'b1,
              "insert did not grow count")
   `CHECK_CLK(a_miss_holds, acc && (status_in == ST_MISS) |=> $stable(count_ff),
              "miss changed count")

endmodule

/* rtl/core/oils_cell.sv */
`timescale 1ns / 1ps

module oils_cell
   import oils_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [CNT_W-1:0]    count,
   input  logic [VALUE_W-1:0]  value,
   input  logic [VALUE_W-1:0]  left_data,
   input  logic [VALUE_W-1:0]  right_data,
   input  logic                hit_in,
   output logic                hit_out,
   output logic [VALUE_W-1:0]  data_out
);

   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(IDX);

   logic [VALUE_W-1:0] data_ff;
   logic [VALUE_W-1:0] data_in;
   logic               occupied;
   logic               is_tail;

   assign occupied = (MY_POS < count);
   assign is_tail  = (MY_POS == count);

   // first-match chain: a cell at or after the match closes the gap
   assign hit_out  = hit_in | (occupied & (data_ff == value));
   assign data_out = data_ff;

   // next entry value
   always_comb begin
      data_in = data_ff;
      if (ctrl.ins_head) begin
         data_in = (IDX == 0) ? value : left_data;
      end else if (ctrl.ins_tail) begin
         if (is_tail) begin
            data_in = value;
         end
      end else if (ctrl.rem_head) begin
         data_in = right_data;
      end else if (ctrl.rem_val && hit_out) begin
         data_in = right_data;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import oils_pkg::*;

   localparam int LIST_DEPTH = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1750;

   // one predicted response: head after the command, entry count, status
   typedef struct packed {
      logic [31:0] head_value;
      logic [4:0]  entry_count;
      status_type  status;
   } list_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // [31:0] value
   logic [1:0]  req_tuser = CMD_INS_HEAD;  // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;  // [31:0] head_value, [36:32] entry_count, [38:37] status, [39] zero

   // shadow copy of the list, index 0 is the head
   logic [31:0]     shadow_list[$];
   list_report_type pending_reports[$];

   bit steady = 1'b0;
   int error_count = 0;
   int cmds_sent = 0;
   int reports_checked = 0;
   int full_rejects = 0;
   int misses = 0;
   int value_hits = 0;

   ordered_int_list_store #(
      .CAPACITY(LIST_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #2 clock = ~clock;

   // apply one command to the shadow list and report the outcome
   function automatic list_report_type apply_list_cmd(cmd_type cmd, logic [31:0] value);
      list_report_type rep;
      int hit;
      rep.status = ST_OK;
      hit = -1;
      case (cmd)
         CMD_INS_HEAD, CMD_INS_TAIL: begin
            if (shadow_list.size() >= LIST_DEPTH) begin
               rep.status = ST_FULL;
               full_rejects++;
            end else if (cmd == CMD_INS_HEAD) begin
               shadow_list.push_front(value);
            end else begin
               shadow_list.push_back(value);
            end
         end
         CMD_REM_VAL: begin
            // first match from the head wins
            for (int k = 0; k < shadow_list.size() && hit < 0; k++)
               if (shadow_list[k] == value) hit = k;
            if (hit < 0) begin
               rep.status = ST_MISS;
               misses++;
            end else begin
               shadow_list.delete(hit);
               value_hits++;
            end
         end
         default: begin
            if (shadow_list.size() == 0) begin
               rep.status = ST_MISS;
               misses++;
            end else begin
               void'(shadow_list.pop_front());
            end
         end
      endcase
      rep.head_value = (shadow_list.size() > 0) ? shadow_list[0] : 32'd0;
      rep.entry_count = 5'(shadow_list.size());
      return rep;
   endfunction

   // drive one command and wait for its transfer
   task automatic send_cmd(input cmd_type cmd, input logic [31:0] value);
      // idle cycles before the command, about one cycle in five
      while (!steady && $urandom_range(0, 99) < 21) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_reports.push_back(apply_list_cmd(cmd, value));
      cmds_sent++;
   endtask

   // value mix: extremes, a small pool for duplicates, and anything
   function automatic logic [31:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return 32'h0;
         endcase
      end else if (roll < 45) begin
         return 32'($urandom_range(0, 7)) - 32'd3;
      end
      return $urandom;
   endfunction

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 21);
   end

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      list_report_type exp_rep;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $error("response with no command outstanding: %h", rsp_tdata);
            error_count++;
         end else begin
            exp_rep = pending_reports.pop_front();
            reports_checked++;
            if (rsp_tdata[31:0] !== exp_rep.head_value) begin
               $error("head_value: expected %0d, got %0d",
                      $signed(exp_rep.head_value), $signed(rsp_tdata[31:0]));
               error_count++;
            end
            if (rsp_tdata[36:32] !== exp_rep.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      exp_rep.entry_count, rsp_tdata[36:32]);
               error_count++;
            end
            if (rsp_tdata[38:37] !== exp_rep.status) begin
               $error("status: expected %0d, got %0d", exp_rep.status, rsp_tdata[38:37]);
               error_count++;
            end
            if (rsp_tdata[39] !== 1'b0) begin
               $error("pad: expected 0, got %b", rsp_tdata[39]);
               error_count++;
            end
         end
      end
   end

   // give up after a long stretch with no transfer on either side
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("** ordered_int_list_store: FAILED **");
      $finish;
   end

   // removals on an empty list
   task automatic test_empty_list();
      send_cmd(CMD_REM_HEAD, 32'h1234_5678);
      send_cmd(CMD_REM_VAL, 32'h0);
      send_cmd(CMD_REM_VAL, 32'h8000_0000);
   endtask

   // one entry in, one entry out, both ways
   task automatic test_single_entry();
      send_cmd(CMD_INS_HEAD, 32'h7fff_ffff);
      send_cmd(CMD_REM_VAL, 32'h7fff_ffff);
      send_cmd(CMD_INS_TAIL, 32'h0000_0005);
      send_cmd(CMD_REM_HEAD, 32'hffff_ffff);
   endtask

   // fill to capacity with duplicates, then push against the full list
   task automatic test_fill_and_full();
      logic [31:0] fill_vals[16] = '{
         32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0000,
         32'h0000_0001, 32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0007,
         32'h0000_0007, 32'hdead_beef, 32'h0000_0007, 32'h8000_0001,
         32'h7fff_fffe, 32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h0000_0002
      };
      for (int k = 0; k < 16; k++)
         send_cmd((k % 2) ? CMD_INS_TAIL : CMD_INS_HEAD, fill_vals[k]);
      send_cmd(CMD_INS_HEAD, 32'h1111_1111);
      send_cmd(CMD_INS_TAIL, 32'h2222_2222);
   endtask

   // duplicate removal takes the copy nearest the head; absent value misses
   task automatic test_duplicates();
      send_cmd(CMD_REM_VAL, 32'h0000_0007);
      send_cmd(CMD_REM_VAL, 32'h3333_3333);
   endtask

   // random traffic in phases that lean toward filling or draining
   task automatic test_random_traffic(input int n_items);
      int fill_pct;
      cmd_type cmd;
      logic [31:0] value;
      fill_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (i % 64 == 0) begin
            case ($urandom_range(0, 2))
               0: fill_pct = 80;
               1: fill_pct = 20;
               default: fill_pct = 50;
            endcase
         end
         steady = (i >= 700 && i < 1000);
         if ($urandom_range(0, 99) < fill_pct) begin
            cmd = $urandom_range(0, 1) ? CMD_INS_TAIL : CMD_INS_HEAD;
            value = pick_value();
         end else begin
            cmd = $urandom_range(0, 1) ? CMD_REM_VAL : CMD_REM_HEAD;
            if (shadow_list.size() > 0 && $urandom_range(0, 99) < 60)
               value = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
            else
               value = pick_value();
         end
         send_cmd(cmd, value);
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_single_entry();
      test_fill_and_full();
      test_duplicates();
      test_random_traffic(RANDOM_ITEMS);
      req_tvalid <= 1'b0;

      // drain outstanding responses, then watch for strays
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d commands, checked %0d responses", cmds_sent, reports_checked);
      $display("full rejects %0d, misses %0d, removals by value %0d",
               full_rejects, misses, value_hits);
      if (error_count == 0) begin
         $display("** ordered_int_list_store: PASSED **");
      end else begin
         $display("** ordered_int_list_store: FAILED **");
      end
      $finish;
   end

endmodule
